[hdl/paged_block_free_list_allocator_defines.svh]
// Assertion macros used by the checker file.
`ifndef PAGED_BLOCK_FREE_LIST_ALLOCATOR_DEFINES_SVH
`define PAGED_BLOCK_FREE_LIST_ALLOCATOR_DEFINES_SVH

// Check a property on every clock edge outside reset.
`define PBFA_ASSERT(label, prop, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) prop) \
        else $error(msg);

// Check that a condition implies another one on the next clock edge.
`define PBFA_ASSERT_NEXT(label, pre, post, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (pre) |=> (post)) \
        else $error(msg);

`endif

[hdl/pbfa_pkg.sv]
package pbfa_pkg;

    // Fixed field widths
    localparam int ID_W    = 6;
    localparam int CNT_W   = 7;
    localparam int TOK_W   = 14;
    localparam int TPB_W   = 9;
    localparam int DVD_W   = TOK_W + 1;
    localparam int DVS_W   = TPB_W;
    localparam int APB_AW  = 3;
    localparam int APB_DW  = 32;

    // Register reset values
    localparam logic [TPB_W-1:0] TPB_RESET = 9'd16;
    localparam logic [CNT_W-1:0] BIU_RESET = 7'd64;

    // Register indexes (bit 2 of the byte address)
    localparam logic REG_TPB = 1'b0;
    localparam logic REG_BIU = 1'b1;

    // Request codes
    localparam logic [1:0] MODE_BLOCKS = 2'd0;
    localparam logic [1:0] MODE_TOKENS = 2'd1;
    localparam logic [1:0] MODE_FREE   = 2'd2;
    localparam logic [1:0] MODE_NONE   = 2'd3;

    typedef enum logic [1:0] {
        STAT_OK    = 2'd0,
        STAT_SHORT = 2'd1,
        STAT_RANGE = 2'd2,
        STAT_FULL  = 2'd3
    } t_status;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_DIV,
        ST_CHECK,
        ST_POP_RD,
        ST_POP_WR,
        ST_REPORT
    } t_state;

    typedef struct packed {
        logic [1:0]       mode;
        logic [CNT_W-1:0] block_count;
        logic [TOK_W-1:0] token_count;
        logic [ID_W-1:0]  freed_id;
    } t_in_item;

    typedef struct packed {
        logic [ID_W-1:0]  granted_id;
        logic             has_block;
        t_status          status;
        logic             last;
        logic [CNT_W-1:0] free_count;
    } t_out_item;

    // Control strobes from the sequencer to the stack memory
    typedef struct packed {
        logic refill;
        logic rd_en;
        logic wr_en;
    } t_stk_ctl;

endpackage

[hdl/pbfa_div.sv]
module pbfa_div (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        i_start,
    input  logic [pbfa_pkg::DVD_W-1:0]  i_dividend,
    input  logic [pbfa_pkg::DVS_W-1:0]  i_divisor,
    output logic                        o_done,
    output logic [pbfa_pkg::DVD_W-1:0]  o_quotient
);

    localparam int DVD_W = pbfa_pkg::DVD_W;
    localparam int DVS_W = pbfa_pkg::DVS_W;
    localparam int CW    = $clog2(DVD_W);

    logic             r_busy;
    logic             r_done;
    logic [CW-1:0]    r_cnt;
    logic [DVD_W-1:0] r_q;
    logic [DVS_W-1:0] r_rem;
    logic [DVS_W-1:0] r_dvs;
    logic [DVS_W:0]   w_trial;
    logic             w_fit;
    logic [DVS_W:0]   w_diff;

    // One restoring step: shift in the next dividend bit, subtract if it fits
    always_comb begin
        w_trial = {r_rem, r_q[DVD_W-1]};
        w_fit   = (w_trial >= {1'b0, r_dvs});
        w_diff  = w_trial - {1'b0, r_dvs};
    end

    // Sequence control
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_busy <= 1'b1;
                r_cnt  <= '0;
            end else if (r_busy) begin
                r_cnt <= r_cnt + CW'(1);
                if (r_cnt == CW'(DVD_W - 1)) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    // Datapath: quotient bits shift in where dividend bits shift out
    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_q   <= i_dividend;
            r_rem <= '0;
            r_dvs <= i_divisor;
        end else if (r_busy) begin
            r_q   <= {r_q[DVD_W-2:0], w_fit};
            r_rem <= w_fit ? w_diff[DVS_W-1:0] : w_trial[DVS_W-1:0];
        end
    end

    assign o_done     = r_done;
    assign o_quotient = r_q;

endmodule

[hdl/pbfa_stack.sv]
module pbfa_stack #(
    parameter int MAX_BLOCKS = 64,
    localparam int AW = (MAX_BLOCKS > 1) ? $clog2(MAX_BLOCKS) : 1,
    localparam int DW = $clog2(MAX_BLOCKS + 1)
) (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  pbfa_pkg::t_stk_ctl         i_ctl,
    input  logic [DW-1:0]              i_pool,
    input  logic [AW-1:0]              i_rd_addr,
    input  logic [AW-1:0]              i_wr_addr,
    input  logic [pbfa_pkg::ID_W-1:0]  i_wr_data,
    output logic [pbfa_pkg::ID_W-1:0]  o_rd_data
);

    localparam int ID_W = pbfa_pkg::ID_W;

    logic [ID_W-1:0] r_mem [MAX_BLOCKS];
    logic [ID_W-1:0] r_mem_q;
    logic [ID_W-1:0] r_init_q;
    logic            r_fresh_q;
    logic [DW-1:0]   r_low;
    logic [ID_W:0]   w_init;

    // Entries below the low mark have not been pushed since the last refill
    // and read as the descending fill value pool-1-index.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_low <= DW'(MAX_BLOCKS);
        end else if (i_ctl.refill) begin
            r_low <= DW'(MAX_BLOCKS);
        end else if (i_ctl.wr_en && (DW'(i_wr_addr) < r_low)) begin
            r_low <= DW'(i_wr_addr);
        end
    end

    assign w_init = (ID_W+1)'(i_pool) - (ID_W+1)'(1) - (ID_W+1)'(i_rd_addr);

    // Write port
    always_ff @(posedge i_clk) begin
        if (i_ctl.wr_en) begin
            r_mem[i_wr_addr] <= i_wr_data;
        end
    end

    // Registered read port, with the fill value resolved at read time
    always_ff @(posedge i_clk) begin
        if (i_ctl.rd_en) begin
            r_mem_q   <= r_mem[i_rd_addr];
            r_init_q  <= w_init[ID_W-1:0];
            r_fresh_q <= (DW'(i_rd_addr) < r_low);
        end
    end

    assign o_rd_data = r_fresh_q ? r_init_q : r_mem_q;

endmodule

[hdl/paged_block_free_list_allocator.sv]
// Block allocator over a LIFO free stack of cache-block ids held in one
// synchronous memory. One request is handled at a time. A free or an unused
// code gives a single result, as does a zero or refused allocation by block
// count. An allocation by block count is checked first; each granted id then
// takes a memory read and a result. An allocation by token count first runs
// the bit-serial divider that rounds the token count up to blocks. Results
// wait in an output register, so a stalled consumer only delays the next
// pop. Writing blocks_in_use refills the stack at once: no clearing pass is
// needed, never-pushed entries read as their fill value.
// Configuration may be written only while no request is in flight.
module paged_block_free_list_allocator #(
    parameter int MAX_BLOCKS = 64
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_in_valid,
    output logic                          o_in_ready,
    input  pbfa_pkg::t_in_item            i_in,
    output logic                          o_out_valid,
    input  logic                          i_out_ready,
    output pbfa_pkg::t_out_item           o_out,
    input  logic                          psel,
    input  logic                          penable,
    input  logic                          pwrite,
    input  logic [pbfa_pkg::APB_AW-1:0]   paddr,
    input  logic [pbfa_pkg::APB_DW-1:0]   pwdata,
    output logic [pbfa_pkg::APB_DW-1:0]   prdata,
    output logic                          pready
);

    localparam int AW    = (MAX_BLOCKS > 1) ? $clog2(MAX_BLOCKS) : 1;
    localparam int DW    = $clog2(MAX_BLOCKS + 1);
    localparam int ID_W  = pbfa_pkg::ID_W;
    localparam int CNT_W = pbfa_pkg::CNT_W;
    localparam int TPB_W = pbfa_pkg::TPB_W;
    localparam int DVD_W = pbfa_pkg::DVD_W;

    function automatic logic [DW-1:0] pool_of(input logic [CNT_W-1:0] b);
        logic [DW-1:0] n;
        n = DW'(b);
        if (b == '0) begin
            n = DW'(1);
        end else if (int'(b) > MAX_BLOCKS) begin
            n = DW'(MAX_BLOCKS);
        end
        return n;
    endfunction

    pbfa_pkg::t_state    r_state, n_state;
    logic [TPB_W-1:0]    r_tpb, n_tpb;
    logic [CNT_W-1:0]    r_biu, n_biu;
    logic [DW-1:0]       r_depth, n_depth;
    logic [DVD_W-1:0]    r_need, n_need;
    logic [DW-1:0]       r_remain, n_remain;
    pbfa_pkg::t_status   r_rep_status, n_rep_status;
    logic                r_out_valid;
    pbfa_pkg::t_out_item r_out, n_out;

    logic                w_accept;
    logic                w_cfg_wr;
    logic                w_slot;
    logic                w_load;
    logic [DW-1:0]       w_pool;
    logic [TPB_W-1:0]    w_bs;
    pbfa_pkg::t_stk_ctl  w_stk_ctl;
    logic [AW-1:0]       w_rd_addr;
    logic [AW-1:0]       w_wr_addr;
    logic [ID_W-1:0]     w_wr_data;
    logic [ID_W-1:0]     w_rd_data;
    logic                w_div_start;
    logic [DVD_W-1:0]    w_dividend;
    logic                w_div_done;
    logic [DVD_W-1:0]    w_quotient;

    assign w_accept = i_in_valid && o_in_ready;
    assign w_cfg_wr = psel && penable && pwrite && pready;
    assign w_slot   = !r_out_valid || i_out_ready;
    assign w_pool   = pool_of(r_biu);
    assign w_bs     = (r_tpb == '0) ? TPB_W'(1) : r_tpb;

    // Configuration read back
    assign pready = 1'b1;
    always_comb begin
        unique case (paddr[2])
            pbfa_pkg::REG_TPB: prdata = pbfa_pkg::APB_DW'(r_tpb);
            pbfa_pkg::REG_BIU: prdata = pbfa_pkg::APB_DW'(r_biu);
            default:           prdata = '0;
        endcase
    end

    // Next state
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            pbfa_pkg::ST_IDLE: begin
                if (w_accept) begin
                    case (i_in.mode)
                        pbfa_pkg::MODE_BLOCKS: n_state = pbfa_pkg::ST_CHECK;
                        pbfa_pkg::MODE_TOKENS: n_state = pbfa_pkg::ST_DIV;
                        default:               n_state = pbfa_pkg::ST_REPORT;
                    endcase
                end
            end
            pbfa_pkg::ST_DIV: begin
                if (w_div_done) begin
                    n_state = pbfa_pkg::ST_CHECK;
                end
            end
            pbfa_pkg::ST_CHECK: begin
                if (r_need == '0 || r_need > DVD_W'(r_depth)) begin
                    n_state = pbfa_pkg::ST_REPORT;
                end else begin
                    n_state = pbfa_pkg::ST_POP_RD;
                end
            end
            pbfa_pkg::ST_POP_RD: begin
                n_state = pbfa_pkg::ST_POP_WR;
            end
            pbfa_pkg::ST_POP_WR: begin
                if (w_slot) begin
                    n_state = (r_remain == '0) ? pbfa_pkg::ST_IDLE : pbfa_pkg::ST_POP_RD;
                end
            end
            pbfa_pkg::ST_REPORT: begin
                if (w_slot) begin
                    n_state = pbfa_pkg::ST_IDLE;
                end
            end
            default: n_state = pbfa_pkg::ST_IDLE;
        endcase
    end

    // Outputs and datapath updates
    always_comb begin
        o_in_ready   = 1'b0;
        n_tpb        = r_tpb;
        n_biu        = r_biu;
        n_depth      = r_depth;
        n_need       = r_need;
        n_remain     = r_remain;
        n_rep_status = r_rep_status;
        n_out        = r_out;
        w_load       = 1'b0;
        w_stk_ctl    = '0;
        w_rd_addr    = AW'(r_depth - DW'(1));
        w_wr_addr    = AW'(r_depth);
        w_wr_data    = i_in.freed_id;
        w_div_start  = 1'b0;
        w_dividend   = DVD_W'(i_in.token_count) + DVD_W'(w_bs) - DVD_W'(1);

        unique case (r_state)
            pbfa_pkg::ST_IDLE: begin
                o_in_ready = 1'b1;
                // Register writes; a pool size write refills the stack
                if (w_cfg_wr) begin
                    unique case (paddr[2])
                        pbfa_pkg::REG_TPB: n_tpb = pwdata[TPB_W-1:0];
                        pbfa_pkg::REG_BIU: begin
                            n_biu            = pwdata[CNT_W-1:0];
                            n_depth          = pool_of(pwdata[CNT_W-1:0]);
                            w_stk_ctl.refill = 1'b1;
                        end
                        default: ;
                    endcase
                end
                if (w_accept) begin
                    n_rep_status = pbfa_pkg::STAT_OK;
                    case (i_in.mode)
                        pbfa_pkg::MODE_BLOCKS: n_need = DVD_W'(i_in.block_count);
                        pbfa_pkg::MODE_TOKENS: w_div_start = 1'b1;
                        pbfa_pkg::MODE_FREE: begin
                            // Range check first, then full check, then push
                            if (CNT_W'(i_in.freed_id) >= CNT_W'(w_pool)) begin
                                n_rep_status = pbfa_pkg::STAT_RANGE;
                            end else if (r_depth >= w_pool) begin
                                n_rep_status = pbfa_pkg::STAT_FULL;
                            end else begin
                                w_stk_ctl.wr_en = 1'b1;
                                n_depth         = r_depth + DW'(1);
                            end
                        end
                        default: ;
                    endcase
                end
            end
            pbfa_pkg::ST_DIV: begin
                if (w_div_done) begin
                    n_need = w_quotient;
                end
            end
            pbfa_pkg::ST_CHECK: begin
                if (r_need == '0) begin
                    n_rep_status = pbfa_pkg::STAT_OK;
                end else if (r_need > DVD_W'(r_depth)) begin
                    n_rep_status = pbfa_pkg::STAT_SHORT;
                end else begin
                    n_remain = r_need[DW-1:0];
                end
            end
            pbfa_pkg::ST_POP_RD: begin
                // Pop: read the top entry and drop the depth
                w_stk_ctl.rd_en = 1'b1;
                n_depth         = r_depth - DW'(1);
                n_remain        = r_remain - DW'(1);
            end
            pbfa_pkg::ST_POP_WR: begin
                if (w_slot) begin
                    w_load           = 1'b1;
                    n_out.granted_id = w_rd_data;
                    n_out.has_block  = 1'b1;
                    n_out.status     = pbfa_pkg::STAT_OK;
                    n_out.last       = (r_remain == '0);
                    n_out.free_count = CNT_W'(r_depth);
                end
            end
            pbfa_pkg::ST_REPORT: begin
                if (w_slot) begin
                    w_load           = 1'b1;
                    n_out.granted_id = '0;
                    n_out.has_block  = 1'b0;
                    n_out.status     = r_rep_status;
                    n_out.last       = 1'b1;
                    n_out.free_count = CNT_W'(r_depth);
                end
            end
            default: ;
        endcase
    end

    // Control registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= pbfa_pkg::ST_IDLE;
            r_tpb       <= pbfa_pkg::TPB_RESET;
            r_biu       <= pbfa_pkg::BIU_RESET;
            r_depth     <= pool_of(pbfa_pkg::BIU_RESET);
            r_out_valid <= 1'b0;
        end else begin
            r_state <= n_state;
            r_tpb   <= n_tpb;
            r_biu   <= n_biu;
            r_depth <= n_depth;
            if (w_load) begin
                r_out_valid <= 1'b1;
            end else if (i_out_ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    // Payload registers
    always_ff @(posedge i_clk) begin
        r_need       <= n_need;
        r_remain     <= n_remain;
        r_rep_status <= n_rep_status;
        r_out        <= n_out;
    end

    assign o_out_valid = r_out_valid;
    assign o_out       = r_out;

    pbfa_stack #(
        .MAX_BLOCKS (MAX_BLOCKS)
    ) u_stack (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_ctl     (w_stk_ctl),
        .i_pool    (w_pool),
        .i_rd_addr (w_rd_addr),
        .i_wr_addr (w_wr_addr),
        .i_wr_data (w_wr_data),
        .o_rd_data (w_rd_data)
    );

    pbfa_div u_div (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_start    (w_div_start),
        .i_dividend (w_dividend),
        .i_divisor  (w_bs),
        .o_done     (w_div_done),
        .o_quotient (w_quotient)
    );

endmodule

[hdl/pbfa_checker.sv]
`include "paged_block_free_list_allocator_defines.svh"

module pbfa_checker #(
    parameter int MAX_BLOCKS = 64
) (
    input logic                          i_clk,
    input logic                          i_rst_n,
    input logic                          i_in_valid,
    input logic                          o_in_ready,
    input pbfa_pkg::t_in_item            i_in,
    input logic                          o_out_valid,
    input logic                          i_out_ready,
    input pbfa_pkg::t_out_item           o_out,
    input logic                          psel,
    input logic                          penable,
    input logic                          pwrite,
    input logic [pbfa_pkg::APB_AW-1:0]   paddr,
    input logic [pbfa_pkg::APB_DW-1:0]   pwdata,
    input logic [pbfa_pkg::APB_DW-1:0]   prdata,
    input logic                          pready
);

    // Free count never exceeds the pool capacity
    `PBFA_ASSERT(a_free_count_max, o_out_valid |-> (int'(o_out.free_count) <= MAX_BLOCKS), "free count above capacity")

    // A granted block always carries an ok status
    `PBFA_ASSERT(a_grant_ok, (o_out_valid && o_out.has_block) |-> (o_out.status == pbfa_pkg::STAT_OK), "grant with error status")

    // A result without a block shows id zero
    `PBFA_ASSERT(a_no_block_id, (o_out_valid && !o_out.has_block) |-> (o_out.granted_id == '0), "stray id without block")

    // No new request is taken while a grant sequence is still running
    `PBFA_ASSERT(a_busy_in_burst, (o_out_valid && !o_out.last) |-> !o_in_ready, "request taken mid burst")

    // A stalled result holds
    `PBFA_ASSERT_NEXT(a_out_hold, o_out_valid && !i_out_ready, o_out_valid && $stable(o_out), "stalled result changed")

endmodule

bind paged_block_free_list_allocator pbfa_checker #(.MAX_BLOCKS(MAX_BLOCKS)) u_pbfa_checker (.*);
